[design/sts_pkg.sv]
// Shared types and constants for the scheme token scanner.
// Used by the scanner core, the token queue and the top level.
package sts_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NUM  = 2'd1,
        MODE_SYM  = 2'd2
    } scan_mode_t;

    typedef enum logic [2:0] {
        KIND_LPAREN  = 3'd0,
        KIND_RPAREN  = 3'd1,
        KIND_INTEGER = 3'd2,
        KIND_SYMBOL  = 3'd3,
        KIND_QUOTE   = 3'd4,
        KIND_EOF     = 3'd5,
        KIND_INVALID = 3'd6
    } token_kind_t;

    typedef struct packed {
        token_kind_t kind;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic        last_of_run;
    } token_t;

    // up to two tokens produced by one accepted byte
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } token_push_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h27;

endpackage

[design/sts_if.sv]
// Request channel interfaces for the scheme token scanner.
// Depends on nothing; the top level uses them as ports and its testbench instantiates them.
interface sts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_marker;

    modport source (output valid, output ch, output end_marker, input ready);
    modport sink   (input valid, input ch, input end_marker, output ready);
endinterface

interface sts_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic        last_of_run;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input start_offset,
                    input token_length, input last_of_run, output ready);
endinterface

[design/sts_core.sv]
// Scanner core: scan mode, token start and position registers plus byte
// classification. Depends on sts_pkg.
module sts_core #(
    parameter int POS_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           ch,
    input  logic                 end_marker,
    output sts_pkg::token_push_t push
);

    localparam int WIDE_BITS = POS_BITS + 16;

    sts_pkg::scan_mode_t mode_reg, mode_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;

    logic is_digit, is_space, is_initial, grows, pending;
    logic single_valid;
    sts_pkg::token_t flush_tok, single_tok;
    logic [POS_BITS-1:0] len_raw;

    function automatic logic [15:0] sat16(input logic [POS_BITS-1:0] v);
        logic [WIDE_BITS-1:0] w;
        w = {16'b0, v};
        if (w > WIDE_BITS'(17'h0FFFF))
            return 16'hFFFF;
        return w[15:0];
    endfunction

    always_comb
    begin
        is_digit   = ch inside {[8'h30:8'h39]};
        is_space   = ch inside {8'h20, [8'h09:8'h0D]};
        is_initial = ch inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h2B, 8'h2D, 8'h2A,
                                8'h2F, 8'h3C, 8'h3E, 8'h3D, 8'h3F, 8'h21};
        grows   = (mode_reg == sts_pkg::MODE_NUM && is_digit) ||
                  (mode_reg == sts_pkg::MODE_SYM && (is_initial || is_digit));
        pending = mode_reg != sts_pkg::MODE_IDLE;
        len_raw = pos_reg - start_reg;

        flush_tok.kind = (mode_reg == sts_pkg::MODE_NUM) ?
                         sts_pkg::KIND_INTEGER : sts_pkg::KIND_SYMBOL;
        flush_tok.start_offset = sat16(start_reg);
        flush_tok.token_length = sat16(len_raw);
        flush_tok.last_of_run  = 1'b0;

        single_tok.start_offset = sat16(pos_reg);
        single_tok.token_length = 16'd1;
        single_tok.last_of_run  = 1'b1;
        single_tok.kind         = sts_pkg::KIND_INVALID;
        single_valid = 1'b0;

        mode_next  = mode_reg;
        start_next = start_reg;
        pos_next   = (pos_reg != '1) ? pos_reg + POS_BITS'(1) : pos_reg;

        push.count  = 2'd0;
        push.first  = flush_tok;
        push.second = single_tok;

        if (end_marker)
        begin
            single_valid = 1'b1;
            single_tok.kind = sts_pkg::KIND_EOF;
            single_tok.token_length = 16'd0;
            mode_next  = sts_pkg::MODE_IDLE;
            start_next = '0;
            pos_next   = '0;
        end
        else if (!grows)
        begin
            mode_next = sts_pkg::MODE_IDLE;
            if (is_space)
            begin
                single_valid = 1'b0;
            end
            else if (ch == sts_pkg::CH_LPAREN)
            begin
                single_valid = 1'b1;
                single_tok.kind = sts_pkg::KIND_LPAREN;
            end
            else if (ch == sts_pkg::CH_RPAREN)
            begin
                single_valid = 1'b1;
                single_tok.kind = sts_pkg::KIND_RPAREN;
            end
            else if (ch == sts_pkg::CH_QUOTE)
            begin
                single_valid = 1'b1;
                single_tok.kind = sts_pkg::KIND_QUOTE;
            end
            else if (is_digit)
            begin
                mode_next  = sts_pkg::MODE_NUM;
                start_next = pos_reg;
            end
            else if (is_initial)
            begin
                mode_next  = sts_pkg::MODE_SYM;
                start_next = pos_reg;
            end
            else
            begin
                single_valid = 1'b1;
                single_tok.kind = sts_pkg::KIND_INVALID;
            end
        end

        if (end_marker || !grows)
        begin
            if (pending)
            begin
                flush_tok.last_of_run = !single_valid;
                push.first  = flush_tok;
                push.second = single_tok;
                push.count  = single_valid ? 2'd2 : 2'd1;
            end
            else
            begin
                push.first  = single_tok;
                push.second = single_tok;
                push.count  = single_valid ? 2'd1 : 2'd0;
            end
        end

        if (!accept)
            push.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= sts_pkg::MODE_IDLE;
            start_reg <= '0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

[design/sts_queue.sv]
// Token queue: four entries, up to two writes and one read per cycle.
// Depends on sts_pkg.
module sts_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sts_pkg::token_push_t push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sts_pkg::token_t      out_tok
);

    sts_pkg::token_t entry_reg [sts_pkg::QUEUE_DEPTH];
    logic [sts_pkg::QUEUE_PTR_BITS-1:0] wptr_reg, wptr_next;
    logic [sts_pkg::QUEUE_PTR_BITS-1:0] rptr_reg, rptr_next;
    logic [sts_pkg::QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic pop;

    assign out_valid = count_reg != '0;
    assign out_tok   = entry_reg[rptr_reg];
    assign room      = count_reg <= sts_pkg::QUEUE_CNT_BITS'(sts_pkg::QUEUE_DEPTH - 2);
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wptr_next  = wptr_reg + sts_pkg::QUEUE_PTR_BITS'(push.count);
        rptr_next  = rptr_reg + sts_pkg::QUEUE_PTR_BITS'(pop);
        count_next = count_reg + sts_pkg::QUEUE_CNT_BITS'(push.count)
                     - sts_pkg::QUEUE_CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wptr_reg + sts_pkg::QUEUE_PTR_BITS'(1)] <= push.second;
    end

endmodule

[design/scheme_token_scanner.sv]
// Scheme token scanner top level: byte channel in, token channel out.
// Depends on sts_pkg, sts_if, sts_core and sts_queue.
//
//  channel  dir  payload                                            request
//  src      in   ch[7:0], end_marker                                one byte or end
//  tok      out  token_kind[2:0], start_offset[15:0],
//                token_length[15:0], last_of_run                    one token
//
// One byte is taken per cycle while src.ready is high; its tokens (zero,
// one or two) land in a four-entry queue the same edge and are offered
// from the next cycle. src.ready is high while the queue has at least two
// free entries. Output stalls fill the queue and then hold src.ready low;
// reset clears the scan state and empties the queue.
module scheme_token_scanner #(
    parameter int POS_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    sts_byte_if.sink        src,
    sts_token_if.source     tok
);

    sts_pkg::token_push_t push;
    sts_pkg::token_t      out_tok;
    logic                 room;
    logic                 accept;

    assign src.ready = room;
    assign accept    = src.valid && room;

    sts_core #(
        .POS_BITS (POS_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .ch         (src.ch),
        .end_marker (src.end_marker),
        .push       (push)
    );

    sts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (tok.valid),
        .out_ready (tok.ready),
        .out_tok   (out_tok)
    );

    assign tok.token_kind   = out_tok.kind;
    assign tok.start_offset = out_tok.start_offset;
    assign tok.token_length = out_tok.token_length;
    assign tok.last_of_run  = out_tok.last_of_run;

endmodule

[tb/tb_top.sv]
// Self-checking bench for scheme_token_scanner: a directed token table, then
// random Scheme-like sources and byte noise checked against a lexer model.
// Depends on sts_pkg, sts_if and the scanner RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_BITS = 16;
    localparam logic [POS_BITS-1:0] POS_LIMIT = '1;
    localparam int RANDOM_BYTES = 525;
    localparam logic [71:0] SYM_SPECIALS = "+-*/<>=?!";

    typedef struct packed {
        logic [7:0]      ch;
        logic            em;
        logic            typed;
        logic [1:0]      n;
        sts_pkg::token_t t0;
        sts_pkg::token_t t1;
    } dir_row_t;

    localparam sts_pkg::token_t NO_TOK = '0;

    // typed rows carry their tokens, the others go through the lexer model
    localparam dir_row_t DIRECTED [25] = '{
        '{sts_pkg::CH_LPAREN, 1'b0, 1'b1, 2'd1,
          '{sts_pkg::KIND_LPAREN, 16'd0, 16'd1, 1'b1}, NO_TOK},
        '{sts_pkg::CH_RPAREN, 1'b0, 1'b1, 2'd1,
          '{sts_pkg::KIND_RPAREN, 16'd1, 16'd1, 1'b1}, NO_TOK},
        '{sts_pkg::CH_QUOTE,  1'b0, 1'b1, 2'd1,
          '{sts_pkg::KIND_QUOTE, 16'd2, 16'd1, 1'b1}, NO_TOK},
        '{8'hFF, 1'b0, 1'b1, 2'd1,
          '{sts_pkg::KIND_INVALID, 16'd3, 16'd1, 1'b1}, NO_TOK},
        '{8'h00, 1'b0, 1'b1, 2'd1,
          '{sts_pkg::KIND_INVALID, 16'd4, 16'd1, 1'b1}, NO_TOK},
        '{" ",                1'b0, 1'b1, 2'd0, NO_TOK, NO_TOK},
        '{"0",                1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"9",                1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
        '{sts_pkg::CH_RPAREN, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"z",                1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"!",                1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"7",                1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
        '{8'h09,              1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"A",                1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
        '{sts_pkg::CH_LPAREN, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"+",                1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
        '{8'h0D,              1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"5",                1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"x",                1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"3",                1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
        '{8'h80,              1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"<",                1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
        '{8'h00, 1'b1, 1'b1, 2'd2,
          '{sts_pkg::KIND_SYMBOL, 16'd21, 16'd1, 1'b0},
          '{sts_pkg::KIND_EOF, 16'd22, 16'd0, 1'b1}},
        '{8'hFF, 1'b1, 1'b1, 2'd1,
          '{sts_pkg::KIND_EOF, 16'd0, 16'd0, 1'b1}, NO_TOK},
        '{8'h0C,              1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic no_idle;
    dir_row_t bus_row;

    sts_byte_if  src_if ();
    sts_token_if tok_if ();

    scheme_token_scanner #(.POS_BITS(POS_BITS)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_if),
        .tok   (tok_if)
    );

    always #6 clk = ~clk;

    // lexer model state
    sts_pkg::scan_mode_t   lex_mode = sts_pkg::MODE_IDLE;
    logic [POS_BITS-1:0]   lex_start = '0;
    logic [POS_BITS-1:0]   lex_pos = '0;
    sts_pkg::token_t       lex_out[$];
    sts_pkg::token_t       lexed_tokens[$];
    logic [7:0]            text[$];

    int bytes_fed;
    int sources_ended;
    int tokens_seen;
    int bad_fields;

    task automatic emit_tok(input sts_pkg::token_t t);
        lex_out = {lex_out, t};
    endtask

    task automatic expect_tok(input sts_pkg::token_t t);
        lexed_tokens = {lexed_tokens, t};
    endtask

    task automatic put_char(input logic [7:0] c);
        text = {text, c};
    endtask

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_initial(logic [7:0] c);
        logic special;
        special = 1'b0;
        for (int i = 0; i < 9; i++)
            if (c == SYM_SPECIALS[8*i +: 8])
                special = 1'b1;
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || special;
    endfunction

    function automatic logic is_subsequent(logic [7:0] c);
        return is_initial(c) || is_digit(c);
    endfunction

    function automatic sts_pkg::token_t make_token(sts_pkg::token_kind_t kind,
                                                   logic [POS_BITS-1:0] off,
                                                   longint unsigned len);
        sts_pkg::token_t t;
        longint unsigned o;
        o = off;
        t.kind = kind;
        t.start_offset = o > 64'hFFFF ? 16'hFFFF : o[15:0];
        t.token_length = len > 64'hFFFF ? 16'hFFFF : len[15:0];
        t.last_of_run = 1'b0;
        return t;
    endfunction

    task automatic flush_token();
        longint unsigned len;
        if (lex_mode != sts_pkg::MODE_IDLE)
        begin
            len = lex_pos >= lex_start ? longint'(lex_pos - lex_start) : 0;
            emit_tok(make_token(lex_mode == sts_pkg::MODE_NUM ? sts_pkg::KIND_INTEGER
                                                              : sts_pkg::KIND_SYMBOL,
                                lex_start, len));
        end
        lex_mode = sts_pkg::MODE_IDLE;
    endtask

    task automatic lex_byte(input logic [7:0] c, input logic em);
        sts_pkg::token_t t;
        lex_out.delete();
        if (em)
        begin
            flush_token();
            emit_tok(make_token(sts_pkg::KIND_EOF, lex_pos, 0));
            lex_mode = sts_pkg::MODE_IDLE;
            lex_start = '0;
            lex_pos = '0;
        end
        else
        begin
            if (!((lex_mode == sts_pkg::MODE_NUM && is_digit(c)) ||
                  (lex_mode == sts_pkg::MODE_SYM && is_subsequent(c))))
            begin
                flush_token();
                if (c == sts_pkg::CH_LPAREN)
                    emit_tok(make_token(sts_pkg::KIND_LPAREN, lex_pos, 1));
                else if (c == sts_pkg::CH_RPAREN)
                    emit_tok(make_token(sts_pkg::KIND_RPAREN, lex_pos, 1));
                else if (c == sts_pkg::CH_QUOTE)
                    emit_tok(make_token(sts_pkg::KIND_QUOTE, lex_pos, 1));
                else if (is_digit(c))
                begin
                    lex_mode = sts_pkg::MODE_NUM;
                    lex_start = lex_pos;
                end
                else if (is_initial(c))
                begin
                    lex_mode = sts_pkg::MODE_SYM;
                    lex_start = lex_pos;
                end
                else if (!is_space(c))
                    emit_tok(make_token(sts_pkg::KIND_INVALID, lex_pos, 1));
            end
            if (lex_pos != POS_LIMIT)
                lex_pos = lex_pos + 1'b1;
        end
        if (lex_out.size() != 0)
        begin
            t = lex_out[lex_out.size() - 1];
            t.last_of_run = 1'b1;
            lex_out[lex_out.size() - 1] = t;
        end
    endtask

    task automatic check_token();
        sts_pkg::token_t want;
        tokens_seen++;
        if (lexed_tokens.size() == 0)
        begin
            $error("unexpected token: kind %0d start %0d length %0d",
                   tok_if.token_kind, tok_if.start_offset, tok_if.token_length);
            bad_fields++;
            return;
        end
        want = lexed_tokens.pop_front();
        if (tok_if.token_kind !== want.kind)
        begin
            $error("token_kind: expected %0d, got %0d", want.kind, tok_if.token_kind);
            bad_fields++;
        end
        if (tok_if.start_offset !== want.start_offset)
        begin
            $error("start_offset: expected %0d, got %0d", want.start_offset,
                   tok_if.start_offset);
            bad_fields++;
        end
        if (tok_if.token_length !== want.token_length)
        begin
            $error("token_length: expected %0d, got %0d", want.token_length,
                   tok_if.token_length);
            bad_fields++;
        end
        if (tok_if.last_of_run !== want.last_of_run)
        begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                   tok_if.last_of_run);
            bad_fields++;
        end
    endtask

    // tokens leave before this edge's request is lexed
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tok_if.valid && tok_if.ready)
                check_token();
            if (src_if.valid && src_if.ready)
            begin
                lex_byte(src_if.ch, src_if.end_marker);
                if (bus_row.typed)
                begin
                    if (bus_row.n >= 1)
                        expect_tok(bus_row.t0);
                    if (bus_row.n >= 2)
                        expect_tok(bus_row.t1);
                end
                else
                begin
                    foreach (lex_out[i])
                        expect_tok(lex_out[i]);
                end
            end
        end
    end

    always @(posedge clk)
        tok_if.ready <= no_idle || ($urandom_range(99) >= 18);

    function automatic dir_row_t byte_row(logic [7:0] c, logic em);
        dir_row_t r;
        r = '0;
        r.ch = c;
        r.em = em;
        return r;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_initial();
        case ($urandom_range(2))
            0: return 8'("a" + $urandom_range(25));
            1: return 8'("A" + $urandom_range(25));
            default: return SYM_SPECIALS[8*$urandom_range(8) +: 8];
        endcase
    endfunction

    function automatic logic [7:0] rand_subsequent();
        return $urandom_range(3) == 0 ? rand_digit() : rand_initial();
    endfunction

    function automatic logic [7:0] rand_space();
        int k;
        k = $urandom_range(5);
        return k == 0 ? 8'h20 : 8'(8 + k);
    endfunction

    function automatic logic [7:0] rand_stray();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (is_subsequent(c) || is_space(c) || c == sts_pkg::CH_LPAREN ||
               c == sts_pkg::CH_RPAREN || c == sts_pkg::CH_QUOTE);
        return c;
    endfunction

    task automatic send_row(input dir_row_t row);
        while (!no_idle && $urandom_range(99) < 18)
        begin
            src_if.valid <= 1'b0;
            @(posedge clk);
        end
        src_if.valid <= 1'b1;
        src_if.ch <= row.ch;
        src_if.end_marker <= row.em;
        bus_row <= row;
        @(posedge clk);
        while (!src_if.ready)
            @(posedge clk);
        bytes_fed++;
        if (row.em)
            sources_ended++;
    endtask

    task automatic drain();
        src_if.valid <= 1'b0;
        @(posedge clk);
        while (lexed_tokens.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_token();
        case ($urandom_range(9))
            0, 1: put_char(sts_pkg::CH_LPAREN);
            2, 3: put_char(sts_pkg::CH_RPAREN);
            4: put_char(sts_pkg::CH_QUOTE);
            5, 6:
            begin
                repeat ($urandom_range(1, 6))
                    put_char(rand_digit());
            end
            7, 8:
            begin
                put_char(rand_initial());
                repeat ($urandom_range(0, 6))
                    put_char(rand_subsequent());
            end
            default: put_char(rand_stray());
        endcase
        if ($urandom_range(1))
            repeat ($urandom_range(1, 3))
                put_char(rand_space());
    endtask

    // mostly terminated sources; some run on into the next one
    task automatic random_source();
        text.delete();
        repeat ($urandom_range(1, 8))
            add_token();
        foreach (text[i])
            send_row(byte_row(text[i], 1'b0));
        if ($urandom_range(99) < 90)
            send_row(byte_row(8'($urandom_range(255)), 1'b1));
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 12))
            send_row(byte_row(8'($urandom_range(255)), $urandom_range(99) < 10));
    endtask

    initial
    begin
        int rand_base;
        int done;
        rst_n = 1'b0;
        no_idle = 1'b0;
        bus_row = '0;
        src_if.valid = 1'b0;
        src_if.ch = '0;
        src_if.end_marker = 1'b0;
        bytes_fed = 0;
        sources_ended = 0;
        tokens_seen = 0;
        bad_fields = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_row(DIRECTED[i]);
        drain();

        rand_base = bytes_fed;
        while (bytes_fed - rand_base < RANDOM_BYTES)
        begin
            done = bytes_fed - rand_base;
            no_idle <= done >= 150 && done < 300;
            if ($urandom_range(99) < 15)
                noise_burst();
            else
                random_source();
            if ($urandom_range(99) < 5)
                drain();
        end
        no_idle <= 1'b0;
        drain();
        repeat (10) @(posedge clk);

        $display("Fed %0d bytes over %0d end markers; %0d tokens checked, %0d bad fields",
                 bytes_fed, sources_ended, tokens_seen, bad_fields);
        $display("Covered every token kind, pending tokens cut by strays and end markers,");
        $display("sources running on without an end marker and both sides stalling");
        if (bad_fields == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("Timed out with %0d tokens outstanding", lexed_tokens.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
